// File: sv/scpf_pkg.sv
// Shared constants, slot codes and the frame descriptor type of the command packet framer.
`default_nettype none

package scpf_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 64;

  localparam logic [7:0]  START_HI     = 8'hEF;
  localparam logic [7:0]  START_LO     = 8'h01;
  localparam logic [7:0]  TYPE_COMMAND = 8'h01;
  localparam logic [31:0] ADDR_RESET   = 32'hFFFF_FFFF;

  // Position of a result within a fully framed packet.
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_START_HI = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_START_LO = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_3   = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_2   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_1   = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_0   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_TYPE     = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_PAYLOAD  = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_SUM_HI   = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_SUM_LO   = 4'd11;

  typedef struct packed {
    logic        rej;
    logic        hdr;
    logic        close_pkt;
    logic [7:0]  pbyte;
    logic [7:0]  len_hi;
    logic [7:0]  len_lo;
    logic [15:0] sum;
  } frame_desc_t;

endpackage

`default_nettype wire

// File: sv/scpf_frame.sv
// Per-request framing decision and packet state (byte count, running checksum).
`default_nettype none

module scpf_frame #(
  parameter int MAX_PACKET_BYTES = scpf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         item_byte,
  input  wire logic [7:0]         item_len,
  input  wire logic               take,
  output scpf_pkg::frame_desc_t   desc
);

  localparam logic [8:0] LIMIT_LEN = 9'(MAX_PACKET_BYTES - 11);

  logic [7:0]  taken_r, taken_nxt;
  logic [15:0] sum_r, sum_nxt;

  logic        too_long;
  logic        hdr;
  logic [8:0]  len9;
  logic [15:0] base;
  logic [15:0] sum_new;
  logic [7:0]  taken_new;
  logic        close_pkt;

  always_comb begin
    too_long  = (item_len == 8'd0) || ({1'b0, item_len} > LIMIT_LEN);
    hdr       = (taken_r == 8'd0);
    len9      = {1'b0, item_len} + 9'd2;
    base      = hdr ? ({8'd0, scpf_pkg::TYPE_COMMAND} + {15'd0, len9[8]} + {8'd0, len9[7:0]})
                    : sum_r;
    sum_new   = base + {8'd0, item_byte};
    taken_new = (hdr ? 8'd0 : taken_r) + 8'd1;
    close_pkt = (taken_new >= item_len);

    desc.rej       = too_long;
    desc.hdr       = hdr && !too_long;
    desc.close_pkt = close_pkt && !too_long;
    desc.pbyte     = item_byte;
    desc.len_hi    = {7'd0, len9[8]};
    desc.len_lo    = len9[7:0];
    desc.sum       = sum_new;

    taken_nxt = taken_r;
    sum_nxt   = sum_r;
    if (take) begin
      if (too_long || close_pkt) begin
        taken_nxt = 8'd0;
        sum_nxt   = 16'd0;
      end else begin
        taken_nxt = taken_new;
        sum_nxt   = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 8'd0;
      sum_r   <= 16'd0;
    end else begin
      taken_r <= taken_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/scpf_emit.sv
// Byte sequencer: holds one frame descriptor and drives the registered result channel.
`default_nettype none

module scpf_emit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  desc_valid,
  input  wire scpf_pkg::frame_desc_t desc,
  input  wire logic [31:0]           addr,
  output logic                       take,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_packet_end,
  output logic                       out_last_of_run,
  output logic                       out_rejected
);

  logic                          busy_r, busy_nxt;
  scpf_pkg::frame_desc_t         desc_r, desc_nxt;
  logic [scpf_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic                          end_r, end_nxt;
  logic                          last_r, last_nxt;
  logic                          rej_r, rej_nxt;

  logic                          emit_go;
  logic                          last;
  logic [scpf_pkg::SLOT_W-1:0]   end_slot;
  logic [7:0]                    slot_byte;

  always_comb begin
    case (slot_r)
      scpf_pkg::SLOT_START_HI: slot_byte = scpf_pkg::START_HI;
      scpf_pkg::SLOT_START_LO: slot_byte = scpf_pkg::START_LO;
      scpf_pkg::SLOT_ADDR_3:   slot_byte = addr[31:24];
      scpf_pkg::SLOT_ADDR_2:   slot_byte = addr[23:16];
      scpf_pkg::SLOT_ADDR_1:   slot_byte = addr[15:8];
      scpf_pkg::SLOT_ADDR_0:   slot_byte = addr[7:0];
      scpf_pkg::SLOT_TYPE:     slot_byte = scpf_pkg::TYPE_COMMAND;
      scpf_pkg::SLOT_LEN_HI:   slot_byte = desc_r.len_hi;
      scpf_pkg::SLOT_LEN_LO:   slot_byte = desc_r.len_lo;
      scpf_pkg::SLOT_PAYLOAD:  slot_byte = desc_r.rej ? 8'd0 : desc_r.pbyte;
      scpf_pkg::SLOT_SUM_HI:   slot_byte = desc_r.sum[15:8];
      scpf_pkg::SLOT_SUM_LO:   slot_byte = desc_r.sum[7:0];
      default:                 slot_byte = 8'd0;
    endcase
  end

  always_comb begin
    emit_go  = busy_r && (!out_valid_r || out_ready);
    end_slot = desc_r.close_pkt ? scpf_pkg::SLOT_SUM_LO : scpf_pkg::SLOT_PAYLOAD;
    last     = (slot_r == end_slot);
    // next descriptor loads in the same cycle the last byte of this one goes out
    take     = desc_valid && (!busy_r || (emit_go && last));

    busy_nxt = busy_r;
    desc_nxt = desc_r;
    slot_nxt = slot_r;
    if (take) begin
      busy_nxt = 1'b1;
      desc_nxt = desc;
      slot_nxt = desc.hdr ? scpf_pkg::SLOT_START_HI : scpf_pkg::SLOT_PAYLOAD;
    end else if (emit_go && last) begin
      busy_nxt = 1'b0;
    end else if (emit_go) begin
      slot_nxt = slot_r + 4'd1;
    end

    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    rej_nxt       = rej_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = slot_byte;
      end_nxt       = (slot_r == scpf_pkg::SLOT_SUM_LO);
      last_nxt      = last;
      rej_nxt       = desc_r.rej;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= scpf_pkg::SLOT_PAYLOAD;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
    rej_r  <= rej_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_packet_end  = end_r;
  assign out_last_of_run = last_r;
  assign out_rejected    = rej_r;

  assert property (@(posedge clk) disable iff (!rst_n) take |=> busy_r)
    else $error("descriptor taken but sequencer not busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> slot_r <= scpf_pkg::SLOT_SUM_LO)
    else $error("slot out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> last_r && !rej_r)
    else $error("packet end not last of run");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rej_r |-> byte_r == 8'd0 && last_r && !end_r)
    else $error("malformed reject result");

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && desc_r.rej |-> slot_r == scpf_pkg::SLOT_PAYLOAD)
    else $error("rejected request walking slots");

endmodule

`default_nettype wire

// File: sv/sensor_command_packet_framer_unit.sv
// Top level of the command packet framer: input register, address register, framing, sequencer.
//
// Input channel (in_valid/in_ready): one payload byte per request, each carrying
// the packet's payload length. Result channel (out_valid/out_ready): one framed
// byte per transfer, with packet_end on the low checksum byte, last_of_run on
// the final byte a request produces, and rejected on the single zero byte that
// a zero or oversize length gives.
// Config channel (cfg_valid/cfg_ready): writes device_address; always ready.
// Write it only while the block is idle.
// A request's first byte reaches the result register after the input and
// descriptor registers. Throughput: one result byte per cycle while out_ready
// is high, set by the single byte-wide result register; a request yields 1 to
// 12 bytes (9 header bytes on the first payload byte, 2 checksum bytes on the
// last). Requests overlap: the input register takes the next one while the
// sequencer is still emitting. Reset: no packet in progress, checksum zero,
// address 0xFFFFFFFF, both channels empty. A stalled receiver holds the result
// register; the sequencer and then the input register fill and in_ready drops.
`default_nettype none

module sensor_command_packet_framer_unit #(
  parameter int MAX_PACKET_BYTES = scpf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_device_address,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [7:0]  in_payload_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_packet_end,
  output logic             out_last_of_run,
  output logic             out_rejected
);

  logic [31:0] dev_addr_r, dev_addr_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic [7:0]  s1_len_r, s1_len_nxt;
  logic        take;
  logic        in_acc;

  scpf_pkg::frame_desc_t desc;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_ready     = !s1_valid_r || take;
    in_acc       = in_valid && in_ready;
    dev_addr_nxt = (cfg_valid && cfg_ready) ? cfg_device_address : dev_addr_r;

    s1_valid_nxt = s1_valid_r;
    if (in_acc)    s1_valid_nxt = 1'b1;
    else if (take) s1_valid_nxt = 1'b0;
    s1_byte_nxt = in_acc ? in_payload_byte : s1_byte_r;
    s1_len_nxt  = in_acc ? in_payload_length : s1_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= scpf_pkg::ADDR_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      dev_addr_r <= dev_addr_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    s1_len_r  <= s1_len_nxt;
  end

  scpf_frame #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (s1_byte_r),
    .item_len  (s1_len_r),
    .take      (take),
    .desc      (desc)
  );

  scpf_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc_valid      (s1_valid_r),
    .desc            (desc),
    .addr            (dev_addr_r),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_packet_end  (out_packet_end),
    .out_last_of_run (out_last_of_run),
    .out_rejected    (out_rejected)
  );

endmodule

`default_nettype wire

// File: dv/scpf_scoreboard_pkg.sv
// Framed-byte predictor and in-order checker for the command packet framer testbench.
package scpf_scoreboard_pkg;

  typedef struct {
    logic [7:0] data;
    logic       pkt_end;
    logic       run_last;
    logic       rej;
  } frame_byte_t;

  class frame_scoreboard;
    int          max_payload;
    logic [31:0] dev_addr;
    logic [7:0]  taken;
    logic [15:0] csum;
    frame_byte_t frame_q[$];
    int          errors;

    function new(int max_packet_bytes);
      max_payload = max_packet_bytes - 11;
      dev_addr    = scpf_pkg::ADDR_RESET;
      taken       = '0;
      csum        = '0;
      errors      = 0;
    endfunction

    function void set_address(logic [31:0] addr);
      dev_addr = addr;
    endfunction

    function int pending();
      return frame_q.size();
    endfunction

    function void push_byte(logic [7:0] data, logic pkt_end, logic rej);
      frame_byte_t fb;
      fb.data     = data;
      fb.pkt_end  = pkt_end;
      fb.run_last = 1'b0;
      fb.rej      = rej;
      frame_q.push_back(fb);
    endfunction

    // Predict every framed byte one accepted request produces.
    function void note_request(logic [7:0] pb, logic [7:0] plen);
      logic [15:0] flen;
      if (plen == 8'd0 || int'(plen) > max_payload) begin
        taken = '0;
        csum  = '0;
        push_byte(8'h00, 1'b0, 1'b1);
      end else begin
        if (taken == 8'd0) begin
          flen = 16'(plen) + 16'd2;
          push_byte(scpf_pkg::START_HI, 1'b0, 1'b0);
          push_byte(scpf_pkg::START_LO, 1'b0, 1'b0);
          push_byte(dev_addr[31:24], 1'b0, 1'b0);
          push_byte(dev_addr[23:16], 1'b0, 1'b0);
          push_byte(dev_addr[15:8], 1'b0, 1'b0);
          push_byte(dev_addr[7:0], 1'b0, 1'b0);
          push_byte(scpf_pkg::TYPE_COMMAND, 1'b0, 1'b0);
          push_byte(flen[15:8], 1'b0, 1'b0);
          push_byte(flen[7:0], 1'b0, 1'b0);
          csum = 16'(scpf_pkg::TYPE_COMMAND) + 16'(flen[15:8]) + 16'(flen[7:0]);
        end
        push_byte(pb, 1'b0, 1'b0);
        csum  = csum + 16'(pb);
        taken = taken + 8'd1;
        // closes on the length carried by this request, even if it changed
        if (taken >= plen) begin
          push_byte(csum[15:8], 1'b0, 1'b0);
          push_byte(csum[7:0], 1'b1, 1'b0);
          taken = '0;
          csum  = '0;
        end
      end
      frame_q[frame_q.size()-1].run_last = 1'b1;
    endfunction

    function void check_result(logic [7:0] data, logic pkt_end, logic run_last, logic rej);
      frame_byte_t fb;
      if (frame_q.size() == 0) begin
        $error("unexpected result: out_byte %h packet_end %b last_of_run %b rejected %b",
               data, pkt_end, run_last, rej);
        errors++;
      end else begin
        fb = frame_q.pop_front();
        if (data !== fb.data) begin
          $error("out_byte: expected %h, got %h", fb.data, data);
          errors++;
        end
        if (pkt_end !== fb.pkt_end) begin
          $error("out_packet_end: expected %b, got %b", fb.pkt_end, pkt_end);
          errors++;
        end
        if (run_last !== fb.run_last) begin
          $error("out_last_of_run: expected %b, got %b", fb.run_last, run_last);
          errors++;
        end
        if (rej !== fb.rej) begin
          $error("out_rejected: expected %b, got %b", fb.rej, rej);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench of the command packet framer: stimulus, stalls and final verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES   = scpf_pkg::MAX_PACKET_BYTES_DEF;
  localparam int MAX_PAYLOAD = MAX_BYTES - 11;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_device_address = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_payload_byte = '0;
  logic [7:0]  in_payload_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_packet_end;
  logic        out_last_of_run;
  logic        out_rejected;

  scpf_scoreboard_pkg::frame_scoreboard sb = new(MAX_BYTES);
  int in_idle_pct  = 30;
  int out_idle_pct = 30;
  int stall_left   = 0;

  sensor_command_packet_framer_unit #(.MAX_PACKET_BYTES(MAX_BYTES)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_payload_byte    (in_payload_byte),
    .in_payload_length  (in_payload_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_packet_end     (out_packet_end),
    .out_last_of_run    (out_last_of_run),
    .out_rejected       (out_rejected)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      stall_left = gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_byte, out_packet_end, out_last_of_run, out_rejected);
  end

  task automatic send_request(input logic [7:0] pb, input logic [7:0] plen);
    int gap;
    gap = ($urandom_range(0, 99) < in_idle_pct) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_payload_byte   <= pb;
    in_payload_length <= plen;
    do @(posedge clk); while (!in_ready);
    sb.note_request(pb, plen);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_address(input logic [31:0] addr);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_device_address <= addr;
    do @(posedge clk); while (!cfg_ready);
    sb.set_address(addr);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(1, 6));
    if (r < 90) return 8'($urandom_range(7, 20));
    if (r < 95) return 8'(MAX_PAYLOAD);
    return 8'($urandom_range(21, MAX_PAYLOAD));
  endfunction

  // Mostly whole packets with random content; some rejects and cut-short packets.
  task automatic random_traffic(input int n_requests);
    int sent;
    int r;
    int cut;
    logic [7:0] plen;
    sent = 0;
    while (sent < n_requests) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        hold_until_drained();
      if (r < 10) begin
        plen = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        send_request(8'($urandom), plen);
        sent++;
      end else if (r < 18) begin
        plen = 8'($urandom_range(2, 12));
        cut  = $urandom_range(1, plen - 1);
        repeat (cut) send_request(8'($urandom), plen);
        // length changes mid-packet; may close it or leave it open
        send_request(8'($urandom), 8'($urandom_range(1, MAX_PAYLOAD)));
        sent += cut + 1;
      end else begin
        plen = pick_length();
        repeat (plen) send_request(8'($urandom), plen);
        sent += plen;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, address at its reset value
    send_request(8'h00, 8'd1);
    send_request(8'hFF, 8'd1);
    send_request(8'hAA, 8'd0);
    send_request(8'h55, 8'd255);
    send_request(8'h12, 8'(MAX_PAYLOAD + 1));
    send_request(8'h01, 8'd3);
    send_request(8'h80, 8'd3);
    send_request(8'h7F, 8'd3);
    // shorter length mid-packet closes it at once
    send_request(8'h10, 8'd5);
    send_request(8'h20, 8'd5);
    send_request(8'h30, 8'd2);
    // reject abandons the open packet
    send_request(8'hC3, 8'd4);
    send_request(8'h3C, 8'd0);
    send_request(8'h99, 8'd2);
    send_request(8'h66, 8'd2);
    hold_until_drained();
    // longest legal length, then cut short
    send_request(8'h5A, 8'(MAX_PAYLOAD));
    send_request(8'h11, 8'd1);
    // longer length mid-packet keeps it open
    send_request(8'h01, 8'd2);
    send_request(8'h02, 8'd4);
    send_request(8'h03, 8'd4);
    send_request(8'h04, 8'd4);
    hold_until_drained();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_address(32'h0000_0000);
    random_traffic(40);
    hold_until_drained();

    in_idle_pct  = 50;
    out_idle_pct = 50;
    write_address(32'hFFFF_FFFF);
    random_traffic(40);
    hold_until_drained();

    in_idle_pct  = 20;
    out_idle_pct = 60;
    write_address($urandom);
    random_traffic(40);
    hold_until_drained();

    in_idle_pct  = 60;
    out_idle_pct = 10;
    write_address(32'h8000_0001);
    random_traffic(40);
    hold_until_drained();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
